// ===== rtl/hspe_pkg.sv =====
// shared types, constants and helpers of the hermite spline point table evaluator
package hspe_pkg;

	localparam int MAX_POINTS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int ADDR_W     = 4;
	localparam int CNT_W      = 5;
	localparam int PARAM_W    = 24;
	localparam int SEG_W      = PARAM_W - FRAC_BITS;

	typedef enum logic [3:0] {
		OP_CLEAR   = 4'd0,
		OP_APPEND  = 4'd1,
		OP_INSERT  = 4'd2,
		OP_REMOVE  = 4'd3,
		OP_SET_PT  = 4'd4,
		OP_SET_POS = 4'd5,
		OP_SET_VEL = 4'd6,
		OP_CARD    = 4'd7,
		OP_EVAL_C  = 4'd8,
		OP_EVAL_N  = 4'd9,
		OP_READ    = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_FEW   = 2'd3
	} status_t;

	localparam logic [2:0] CFG_TENSION = 3'd0;
	localparam logic [2:0] CFG_SVX     = 3'd1;
	localparam logic [2:0] CFG_SVY     = 3'd2;
	localparam logic [2:0] CFG_EVX     = 3'd3;
	localparam logic [2:0] CFG_EVY     = 3'd4;

	// clamp a wide signed value to 32 bits
	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'h7fff_ffff;
		else if (v < -64'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/hspe_ram.sv =====
// generic single-write, single-read ram with registered read data
module hspe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/hermite_spline_point_table_evaluator_top.sv =====
// point table with shifting edits, cardinal velocities and hermite evaluation
// One item at a time. Insert and remove shift entries through a ram read state and a
// ram write state per moved entry; cardinal works through the interior points one at a
// time; evaluation reads both segment ends and reuses one set of multipliers for both
// halves of the sum. The next item is taken once the result is loaded.
// Reset clears the point count, state, output valid and config registers; rams and data keep contents.
module hermite_spline_point_table_evaluator_top
	import hspe_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [3:0]                opcode,
	input  logic [4:0]                index,
	input  logic signed [31:0]        pos_x,
	input  logic signed [31:0]        pos_y,
	input  logic signed [31:0]        vel_x,
	input  logic signed [31:0]        vel_y,
	input  logic [23:0]               param,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        out_pos_x,
	output logic signed [31:0]        out_pos_y,
	output logic signed [31:0]        out_vel_x,
	output logic signed [31:0]        out_vel_y,
	output logic [4:0]                point_count,
	output logic [1:0]                status,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [31:0]               cfg_data
);

	typedef enum logic [20:0] {
		S_IDLE = 21'd1,
		S_DISP = 21'd2,
		S_SHR  = 21'd4,
		S_SHW  = 21'd8,
		S_PUT  = 21'd16,
		S_RDW  = 21'd32,
		S_CEND = 21'd64,
		S_CRA  = 21'd128,
		S_CRB  = 21'd256,
		S_CDIF = 21'd512,
		S_CMUL = 21'd1024,
		S_CWR  = 21'd2048,
		S_ENRM = 21'd4096,
		S_ECHK = 21'd8192,
		S_ET3  = 21'd16384,
		S_EBAS = 21'd32768,
		S_EM0  = 21'd65536,
		S_EM1  = 21'd131072,
		S_EM2  = 21'd262144,
		S_EOUT = 21'd524288,
		S_DONE = 21'd1048576
	} state_t;

	state_t state_q;

	// item and configuration registers
	op_t                 op_q;
	logic [CNT_W-1:0]    idx_q, cnt_q, k_q;
	logic [31:0]         px_q, py_q, vx_q, vy_q;
	logic [PARAM_W-1:0]  prm_q, cum_q;
	logic signed [17:0]  tens_q;
	logic [31:0]         svx_q, svy_q, evx_q, evy_q;
	status_t             st_q;
	logic [31:0]         rpx_q, rpy_q, rvx_q, rvy_q;

	// ram ports
	logic               we_p, we_v;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic [63:0]        wdata_p, wdata_v, rd_p, rd_v;

	// arithmetic registers
	logic signed [31:0] ax_q, ay_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [51:0] cpx_q, cpy_q;
	logic [FRAC_BITS-1:0] t2_q, t3_q;
	logic signed [31:0] p0x_q, p0y_q, m0x_q, m0y_q, p1x_q, p1y_q, m1x_q, m1y_q;
	logic signed [19:0] b00_q, b10_q, b01_q, b11_q;
	logic signed [51:0] pax_q, pbx_q, pay_q, pby_q;
	logic signed [53:0] accx_q, accy_q;

	// output register
	logic               ov_q;
	logic [31:0]        opx_q, opy_q, ovx_q, ovy_q;
	logic [CNT_W-1:0]   ocnt_q;
	status_t            ost_q;

	logic [CNT_W-1:0]   km1, kp1, cntm1, app_idx;
	logic [SEG_W-1:0]   seg;
	logic [ADDR_W-1:0]  seg_a;
	logic [FRAC_BITS-1:0] t_w;
	logic [2*FRAC_BITS-1:0] sq, cube;
	logic signed [18:0] scale;
	logic signed [19:0] t_s, t2_s, t3_s;
	logic signed [31:0] opa_x, opa_y, opb_x, opb_y;
	logic signed [19:0] wa, wb;
	logic signed [51:0] crd_x, crd_y;
	logic signed [53:0] rnd_x, rnd_y;
	logic               out_free;

	assign km1     = k_q - CNT_W'(1);
	assign kp1     = k_q + CNT_W'(1);
	assign cntm1   = cnt_q - CNT_W'(1);
	assign app_idx = (op_q == OP_APPEND) ? cnt_q : idx_q;
	assign seg     = cum_q[PARAM_W-1:FRAC_BITS];
	assign seg_a   = seg[ADDR_W-1:0];
	assign t_w     = cum_q[FRAC_BITS-1:0];
	assign sq      = t_w * t_w;
	assign cube    = t2_q * t_w;
	assign scale   = 19'sd65536 - 19'(tens_q);
	assign t_s     = signed'(20'(t_w));
	assign t2_s    = signed'(20'(t2_q));
	assign t3_s    = signed'(20'(t3_q));

	// shared multiplier operands: first half of the sum, then second
	assign opa_x = (state_q == S_EM0) ? p0x_q : p1x_q;
	assign opa_y = (state_q == S_EM0) ? p0y_q : p1y_q;
	assign opb_x = (state_q == S_EM0) ? m0x_q : m1x_q;
	assign opb_y = (state_q == S_EM0) ? m0y_q : m1y_q;
	assign wa    = (state_q == S_EM0) ? b00_q : b01_q;
	assign wb    = (state_q == S_EM0) ? b10_q : b11_q;

	assign crd_x = (cpx_q + 52'sd65536) >>> 17;
	assign crd_y = (cpy_q + 52'sd65536) >>> 17;
	assign rnd_x = (accx_q + 54'sd32768) >>> FRAC_BITS;
	assign rnd_y = (accy_q + 54'sd32768) >>> FRAC_BITS;

	assign out_free  = !ov_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign out_valid   = ov_q;
	assign out_pos_x   = opx_q;
	assign out_pos_y   = opy_q;
	assign out_vel_x   = ovx_q;
	assign out_vel_y   = ovy_q;
	assign point_count = ocnt_q;
	assign status      = ost_q;

	hspe_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_pos_ram (
		.clk(clk), .we(we_p), .waddr(waddr), .wdata(wdata_p), .raddr(raddr), .rdata(rd_p)
	);

	hspe_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_vel_ram (
		.clk(clk), .we(we_v), .waddr(waddr), .wdata(wdata_v), .raddr(raddr), .rdata(rd_v)
	);

	// ram address and write control per state
	always_comb begin
		we_p    = 1'b0;
		we_v    = 1'b0;
		waddr   = k_q[ADDR_W-1:0];
		raddr   = k_q[ADDR_W-1:0];
		wdata_p = {py_q, px_q};
		wdata_v = {vy_q, vx_q};
		case (state_q)
			S_DISP: begin
				case (op_q)
					OP_SET_PT, OP_SET_POS, OP_SET_VEL: begin
						waddr = idx_q[ADDR_W-1:0];
						if (idx_q < cnt_q) begin
							we_p = (op_q != OP_SET_VEL);
							we_v = (op_q != OP_SET_POS);
						end
					end
					OP_READ: raddr = idx_q[ADDR_W-1:0];
					OP_CARD: begin
						waddr   = '0;
						wdata_v = {svy_q, svx_q};
						we_v    = (cnt_q >= CNT_W'(2));
					end
					default: ;
				endcase
			end
			S_SHR: raddr = (op_q == OP_REMOVE) ? kp1[ADDR_W-1:0] : km1[ADDR_W-1:0];
			S_SHW: begin
				we_p    = 1'b1;
				we_v    = 1'b1;
				wdata_p = rd_p;
				wdata_v = rd_v;
			end
			S_PUT: begin
				waddr = idx_q[ADDR_W-1:0];
				we_p  = 1'b1;
				we_v  = 1'b1;
			end
			S_CEND: begin
				waddr   = cntm1[ADDR_W-1:0];
				wdata_v = {evy_q, evx_q};
				we_v    = 1'b1;
			end
			S_CRA: raddr = km1[ADDR_W-1:0];
			S_CRB: raddr = kp1[ADDR_W-1:0];
			S_CWR: begin
				wdata_v = {sat32(64'(crd_y)), sat32(64'(crd_x))};
				we_v    = 1'b1;
			end
			S_ECHK: raddr = seg_a;
			S_ET3:  raddr = seg_a + ADDR_W'(1);
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tens_q <= '0;
			svx_q  <= '0;
			svy_q  <= '0;
			evx_q  <= '0;
			evy_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TENSION: tens_q <= cfg_data[17:0];
				CFG_SVX:     svx_q  <= cfg_data;
				CFG_SVY:     svy_q  <= cfg_data;
				CFG_EVX:     evx_q  <= cfg_data;
				CFG_EVY:     evy_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && !out_stall && state_q != S_DONE)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DISP;
				S_DISP: begin
					state_q <= S_DONE;
					case (op_q)
						OP_CLEAR: cnt_q <= '0;
						OP_APPEND, OP_INSERT: begin
							if (cnt_q < CNT_W'(MAX_POINTS) && app_idx <= cnt_q)
								state_q <= (cnt_q == app_idx) ? S_PUT : S_SHR;
						end
						OP_REMOVE: begin
							if (idx_q < cnt_q) begin
								if ((6'(idx_q) + 6'd1) < 6'(cnt_q))
									state_q <= S_SHR;
								else
									cnt_q <= cntm1;
							end
						end
						OP_READ: if (idx_q < cnt_q) state_q <= S_RDW;
						OP_CARD: if (cnt_q >= CNT_W'(2)) state_q <= S_CEND;
						OP_EVAL_C: state_q <= S_ECHK;
						OP_EVAL_N: begin
							if (cnt_q >= CNT_W'(2) && prm_q <= PARAM_W'(65536))
								state_q <= S_ENRM;
						end
						default: ;
					endcase
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					if (op_q == OP_REMOVE) begin
						if ((6'(k_q) + 6'd2) < 6'(cnt_q)) begin
							state_q <= S_SHR;
						end else begin
							cnt_q   <= cntm1;
							state_q <= S_DONE;
						end
					end else begin
						state_q <= (km1 == idx_q) ? S_PUT : S_SHR;
					end
				end
				S_PUT: begin
					cnt_q   <= kp1 - k_q + cnt_q;
					state_q <= S_DONE;
				end
				S_RDW:  state_q <= S_DONE;
				S_CEND: state_q <= (cnt_q == CNT_W'(2)) ? S_DONE : S_CRA;
				S_CRA:  state_q <= S_CRB;
				S_CRB:  state_q <= S_CDIF;
				S_CDIF: state_q <= S_CMUL;
				S_CMUL: state_q <= S_CWR;
				S_CWR:  state_q <= ((6'(k_q) + 6'd2) < 6'(cnt_q)) ? S_CRA : S_DONE;
				S_ENRM: state_q <= S_ECHK;
				S_ECHK: begin
					state_q <= S_DONE;
					if (cnt_q >= CNT_W'(2)) begin
						if (seg == SEG_W'(cntm1)) begin
							if (t_w == '0)
								state_q <= S_RDW;
						end else if (seg < SEG_W'(cntm1)) begin
							state_q <= S_ET3;
						end
					end
				end
				S_ET3:  state_q <= S_EBAS;
				S_EBAS: state_q <= S_EM0;
				S_EM0:  state_q <= S_EM1;
				S_EM1:  state_q <= S_EM2;
				S_EM2:  state_q <= S_EOUT;
				S_EOUT: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload, results and arithmetic
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q  <= op_t'(opcode);
				idx_q <= index;
				px_q  <= pos_x;
				py_q  <= pos_y;
				vx_q  <= vel_x;
				vy_q  <= vel_y;
				prm_q <= param;
			end
			S_DISP: begin
				st_q  <= ST_OK;
				rpx_q <= '0;
				rpy_q <= '0;
				rvx_q <= '0;
				rvy_q <= '0;
				cum_q <= prm_q;
				case (op_q)
					OP_CLEAR: ;
					OP_APPEND, OP_INSERT: begin
						idx_q <= app_idx;
						k_q   <= cnt_q;
						if (cnt_q >= CNT_W'(MAX_POINTS))
							st_q <= ST_FULL;
						else if (app_idx > cnt_q)
							st_q <= ST_RANGE;
					end
					OP_REMOVE, OP_SET_PT, OP_SET_POS, OP_SET_VEL, OP_READ: begin
						k_q <= idx_q;
						if (idx_q >= cnt_q)
							st_q <= ST_RANGE;
					end
					OP_CARD: begin
						k_q <= CNT_W'(1);
						if (cnt_q < CNT_W'(2))
							st_q <= ST_FEW;
					end
					OP_EVAL_C: ;
					OP_EVAL_N: begin
						if (cnt_q < CNT_W'(2))
							st_q <= ST_FEW;
						else if (prm_q > PARAM_W'(65536))
							st_q <= ST_RANGE;
					end
					default: st_q <= ST_RANGE;
				endcase
			end
			S_SHW: k_q <= (op_q == OP_REMOVE) ? kp1 : km1;
			S_RDW: begin
				rpx_q <= rd_p[31:0];
				rpy_q <= rd_p[63:32];
				if (op_q == OP_READ) begin
					rvx_q <= rd_v[31:0];
					rvy_q <= rd_v[63:32];
				end
			end
			S_CRB: begin
				ax_q <= rd_p[31:0];
				ay_q <= rd_p[63:32];
			end
			S_CDIF: begin
				dx_q <= 33'(signed'(rd_p[31:0])) - 33'(ax_q);
				dy_q <= 33'(signed'(rd_p[63:32])) - 33'(ay_q);
			end
			S_CMUL: begin
				cpx_q <= 52'(dx_q) * 52'(scale);
				cpy_q <= 52'(dy_q) * 52'(scale);
			end
			S_CWR: k_q <= kp1;
			S_ENRM: cum_q <= PARAM_W'(prm_q[FRAC_BITS:0]) * PARAM_W'(cntm1);
			S_ECHK: begin
				if (cnt_q < CNT_W'(2))
					st_q <= ST_FEW;
				else if (seg > SEG_W'(cntm1) || (seg == SEG_W'(cntm1) && t_w != '0))
					st_q <= ST_RANGE;
				t2_q <= sq[2*FRAC_BITS-1:FRAC_BITS];
			end
			S_ET3: begin
				p0x_q <= rd_p[31:0];
				p0y_q <= rd_p[63:32];
				m0x_q <= rd_v[31:0];
				m0y_q <= rd_v[63:32];
				t3_q  <= cube[2*FRAC_BITS-1:FRAC_BITS];
			end
			S_EBAS: begin
				p1x_q <= rd_p[31:0];
				p1y_q <= rd_p[63:32];
				m1x_q <= rd_v[31:0];
				m1y_q <= rd_v[63:32];
				b00_q <= t3_s + t3_s - t2_s - t2_s - t2_s + 20'sd65536;
				b10_q <= t3_s - t2_s - t2_s + t_s;
				b01_q <= t2_s + t2_s + t2_s - t3_s - t3_s;
				b11_q <= t3_s - t2_s;
			end
			S_EM0, S_EM1: begin
				pax_q <= 52'(opa_x) * 52'(wa);
				pbx_q <= 52'(opb_x) * 52'(wb);
				pay_q <= 52'(opa_y) * 52'(wa);
				pby_q <= 52'(opb_y) * 52'(wb);
				if (state_q == S_EM1) begin
					accx_q <= 54'(pax_q) + 54'(pbx_q);
					accy_q <= 54'(pay_q) + 54'(pby_q);
				end
			end
			S_EM2: begin
				accx_q <= accx_q + 54'(pax_q) + 54'(pbx_q);
				accy_q <= accy_q + 54'(pay_q) + 54'(pby_q);
			end
			S_EOUT: begin
				rpx_q <= sat32(64'(rnd_x));
				rpy_q <= sat32(64'(rnd_y));
			end
			default: ;
		endcase
	end

	// result register beat
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			opx_q  <= (st_q == ST_OK) ? rpx_q : '0;
			opy_q  <= (st_q == ST_OK) ? rpy_q : '0;
			ovx_q  <= (st_q == ST_OK) ? rvx_q : '0;
			ovy_q  <= (st_q == ST_OK) ? rvy_q : '0;
			ocnt_q <= cnt_q;
			ost_q  <= st_q;
		end
	end

endmodule
